### hw/rtl/mupe_pkg.sv
package mupe_pkg;

   localparam int SEQ_BITS_DEFAULT = 16;
   localparam int SEQ_BITS_MIN     = 8;
   localparam int SEQ_BITS_MAX     = 16;

   localparam int KIND_W   = 3;
   localparam int VALUE_W  = 16;
   localparam int BYTE_W   = 8;
   localparam int RETRY_W  = 4;
   localparam int RESULT_W = 4;
   localparam int CMP_W    = VALUE_W + 1;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [BYTE_W-1:0]  AUTOPILOT_COMP  = 8'd1;
   localparam logic [BYTE_W-1:0]  ACK_UNSUPPORTED = 8'd3;
   localparam logic [BYTE_W-1:0]  ACK_CANCELLED   = 8'd15;
   localparam logic [RETRY_W-1:0] RETRY_MAX       = 4'd15;

   typedef enum logic [KIND_W-1:0] {
      KIND_START       = 3'd0,
      KIND_REQUEST     = 3'd1,
      KIND_REQ_INT     = 3'd2,
      KIND_ACK         = 3'd3,
      KIND_TIMEOUT     = 3'd4,
      KIND_CANCEL      = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_COUNT = 2'd1,
      PH_ITEMS = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      SEND_NONE  = 2'd0,
      SEND_COUNT = 2'd1,
      SEND_ITEM  = 2'd2,
      SEND_ACK   = 2'd3
   } send_kind_type;

   typedef enum logic [RESULT_W-1:0] {
      RES_OK          = 4'd0,
      RES_TIMEOUT     = 4'd1,
      RES_PROTOCOL    = 4'd2,
      RES_FRAME       = 4'd3,
      RES_UNSUPPORTED = 4'd4,
      RES_NO_SPACE    = 4'd5,
      RES_PARAM       = 4'd6,
      RES_SEQUENCE    = 4'd7,
      RES_DENIED      = 4'd8,
      RES_CANCELLED   = 4'd9,
      RES_EMPTY       = 4'd10
   } result_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ITEM_COUNT          = 3'd0,
      CSR_PLAN_KIND           = 3'd1,
      CSR_PEER_SYSTEM         = 3'd2,
      CSR_LEGACY_REQUEST_MODE = 3'd3,
      CSR_RETRY_LIMIT         = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [VALUE_W-1:0] item_count;
      logic [BYTE_W-1:0]  peer_system;
      logic               legacy_request_mode;
      logic [RETRY_W-1:0] retry_limit;
   } cfg_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [VALUE_W-1:0] seq;
      logic [BYTE_W-1:0]  ack_code;
      logic [BYTE_W-1:0]  src_system;
      logic [BYTE_W-1:0]  src_component;
   } req_item_type;

   typedef struct packed {
      logic [1:0]          send_kind;
      logic [VALUE_W-1:0]  send_value;
      logic [BYTE_W-1:0]   send_ack_code;
      logic [BYTE_W-1:0]   dest_system;
      logic [BYTE_W-1:0]   dest_component;
      logic                finished;
      logic [RESULT_W-1:0] result_code;
   } rsp_item_type;

   // Raw ack code to dense result; unknown codes depend on whether all items went out
   function automatic logic [RESULT_W-1:0] map_ack(input logic [BYTE_W-1:0] code,
                                                   input logic all_sent);
      logic [RESULT_W-1:0] res;
      begin
         case (code)
            8'd1:    res = RES_PROTOCOL;
            8'd2:    res = RES_FRAME;
            8'd3:    res = RES_UNSUPPORTED;
            8'd4:    res = RES_NO_SPACE;
            8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 8'd10, 8'd11, 8'd12:
                     res = RES_PARAM;
            8'd13:   res = RES_SEQUENCE;
            8'd14:   res = RES_DENIED;
            8'd15:   res = RES_CANCELLED;
            default: res = all_sent ? RES_OK : RES_PROTOCOL;
         endcase
         return res;
      end
   endfunction

   function automatic logic [RETRY_W-1:0] bump_retry(input logic [RETRY_W-1:0] r);
      return (r == RETRY_MAX) ? r : r + RETRY_W'(1);
   endfunction

endpackage

### hw/rtl/mupe_if.sv
interface mupe_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [15:0] seq;
   logic [7:0]  ack_code;
   logic [7:0]  src_system;
   logic [7:0]  src_component;

   modport source (output valid, kind, seq, ack_code, src_system, src_component,
                   input ready);
   modport sink   (input valid, kind, seq, ack_code, src_system, src_component,
                   output ready);
endinterface

interface mupe_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  send_kind;
   logic [15:0] send_value;
   logic [7:0]  send_ack_code;
   logic [7:0]  dest_system;
   logic [7:0]  dest_component;
   logic        finished;
   logic [3:0]  result_code;

   modport source (output valid, send_kind, send_value, send_ack_code, dest_system,
                   dest_component, finished, result_code,
                   input ready);
   modport sink   (input valid, send_kind, send_value, send_ack_code, dest_system,
                   dest_component, finished, result_code,
                   output ready);
endinterface

interface mupe_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/mission_upload_protocol_engine.sv
// Mission upload engine, sender side of the mission upload exchange. Every
// request on req_ch (start, plain request, int request, ack, timeout tick, cancel)
// yields exactly one response on rsp_ch, in order: send_kind tells what to
// transmit (nothing, the count, one item by sequence number, or an ack) and
// finished/result_code report the end of a transfer. Throughput is one request
// per clock while rsp_ch accepts responses; a request goes through the input
// register, then the decode/update logic that writes the response register.
// The phase, next sequence number and retry counter update in that same
// single pass, so back-to-back requests see each other's effect. Registers on csr_ch
// (item count, plan kind, peer system id, legacy request mode, retry limit)
// are always ready and must be written only while no request is in flight.
module mission_upload_protocol_engine #(
   parameter int SEQ_BITS = mupe_pkg::SEQ_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   mupe_req_if.sink   req_ch,
   mupe_rsp_if.source rsp_ch,
   mupe_csr_if.sink   csr_ch
);
   import mupe_pkg::*;

   cfg_type      cfg;
   req_item_type req_item;
   req_item_type item;
   rsp_item_type rsp;
   logic         item_valid;
   logic         advance;
   logic         rsp_valid;

   // Configuration writes never stall
   assign csr_ch.ready = 1'b1;

   mupe_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_ch.valid),
      .wr_index (csr_ch.index),
      .wr_data  (csr_ch.data),
      .cfg      (cfg)
   );

   // Pack the request fields for the input register
   assign req_item.kind          = req_ch.kind;
   assign req_item.seq           = req_ch.seq;
   assign req_item.ack_code      = req_ch.ack_code;
   assign req_item.src_system    = req_ch.src_system;
   assign req_item.src_component = req_ch.src_component;

   mupe_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_ready  (req_ch.ready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   // Decode the held request, update the transfer state, register the response
   mupe_engine #(
      .SEQ_BITS (SEQ_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ch.ready),
      .rsp        (rsp)
   );

   assign rsp_ch.valid          = rsp_valid;
   assign rsp_ch.send_kind      = rsp.send_kind;
   assign rsp_ch.send_value     = rsp.send_value;
   assign rsp_ch.send_ack_code  = rsp.send_ack_code;
   assign rsp_ch.dest_system    = rsp.dest_system;
   assign rsp_ch.dest_component = rsp.dest_component;
   assign rsp_ch.finished       = rsp.finished;
   assign rsp_ch.result_code    = rsp.result_code;
endmodule

### hw/rtl/mupe_csr.sv
module mupe_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_valid,
   input  logic [mupe_pkg::CSR_IDX_W-1:0] wr_index,
   input  logic [mupe_pkg::CSR_DATA_W-1:0] wr_data,
   output mupe_pkg::cfg_type              cfg
);
   import mupe_pkg::*;

   cfg_type cfg_ff;

   // the plan kind reaches no result field, so its writes are taken and dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.item_count          <= '0;
         cfg_ff.peer_system         <= 8'd1;
         cfg_ff.legacy_request_mode <= 1'b0;
         cfg_ff.retry_limit         <= 4'd4;
      end else if (wr_valid) begin
         case (wr_index)
            CSR_ITEM_COUNT:          cfg_ff.item_count <= wr_data[VALUE_W-1:0];
            CSR_PLAN_KIND:           ;
            CSR_PEER_SYSTEM:         cfg_ff.peer_system <= wr_data[BYTE_W-1:0];
            CSR_LEGACY_REQUEST_MODE: cfg_ff.legacy_request_mode <= wr_data[0];
            CSR_RETRY_LIMIT:         cfg_ff.retry_limit <= wr_data[RETRY_W-1:0];
            default:                 ;
         endcase
      end
   end

   assign cfg = cfg_ff;
endmodule

### hw/rtl/mupe_in_reg.sv
module mupe_in_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mupe_pkg::req_item_type req_item,
   input  logic                   advance,
   output logic                   item_valid,
   output mupe_pkg::req_item_type item
);
   import mupe_pkg::*;

   logic         valid_ff;
   req_item_type item_ff;
   logic         take;

   // The slot frees up in the same cycle the engine consumes it
   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= 1'b1;
      end else if (advance) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;
endmodule

### hw/rtl/mupe_engine.sv
module mupe_engine #(
   parameter int SEQ_BITS = mupe_pkg::SEQ_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mupe_pkg::cfg_type      cfg,
   input  logic                   item_valid,
   input  mupe_pkg::req_item_type item,
   output logic                   advance,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output mupe_pkg::rsp_item_type rsp
);
   import mupe_pkg::*;

   localparam int NS_W = SEQ_BITS + 1;

   phase_type           phase_ff, phase_in;
   logic [NS_W-1:0]     next_seq_ff, next_seq_in;
   logic [RETRY_W-1:0]  retry_ff, retry_in;
   rsp_item_type        rsp_ff, rsp_in;
   logic                rsp_valid_ff;

   logic [SEQ_BITS-1:0] seq_m;
   logic [NS_W-1:0]     seq_x;
   logic                busy;
   logic                do_req;
   logic                all_sent;
   logic                retry_out;
   logic [RETRY_W-1:0]  retry_base;

   assign advance   = item_valid && (!rsp_valid_ff || rsp_ready);
   assign seq_m     = item.seq[SEQ_BITS-1:0];
   assign seq_x     = {1'b0, seq_m};
   assign busy      = (phase_ff == PH_COUNT) || (phase_ff == PH_ITEMS);
   assign all_sent  = CMP_W'(next_seq_ff) == CMP_W'(cfg.item_count);
   assign retry_out = retry_ff >= cfg.retry_limit;
   assign do_req    = (item.kind == KIND_REQ_INT)
                   || ((item.kind == KIND_REQUEST) && cfg.legacy_request_mode);
   assign retry_base = (next_seq_ff == seq_x) ? '0 : retry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         next_seq_ff <= '0;
         retry_ff    <= '0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         next_seq_ff <= next_seq_in;
         retry_ff    <= retry_in;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      next_seq_in = next_seq_ff;
      retry_in    = retry_ff;
      rsp_in      = '0;

      if (item.kind == KIND_START) begin
         if (!busy) begin
            if (cfg.item_count == '0) begin
               rsp_in.finished    = 1'b1;
               rsp_in.result_code = RES_EMPTY;
               phase_in           = PH_IDLE;
            end else begin
               phase_in              = PH_COUNT;
               next_seq_in           = '0;
               retry_in              = bump_retry('0);
               rsp_in.send_kind      = SEND_COUNT;
               rsp_in.send_value     = cfg.item_count;
               rsp_in.dest_system    = cfg.peer_system;
               rsp_in.dest_component = AUTOPILOT_COMP;
            end
         end
      end else if (busy) begin
         if (do_req) begin
            phase_in = PH_ITEMS;
            // ahead of the expected number: drop, only the phase moves
            if (next_seq_ff >= seq_x) begin
               if ((next_seq_ff != seq_x) && retry_out) begin
                  rsp_in.finished    = 1'b1;
                  rsp_in.result_code = RES_TIMEOUT;
                  phase_in           = PH_IDLE;
               end else begin
                  retry_in    = retry_base;
                  next_seq_in = seq_x;
                  if (VALUE_W'(seq_m) < cfg.item_count) begin
                     rsp_in.send_kind      = SEND_ITEM;
                     rsp_in.send_value     = VALUE_W'(seq_m);
                     rsp_in.dest_system    = cfg.peer_system;
                     rsp_in.dest_component = AUTOPILOT_COMP;
                     next_seq_in           = seq_x + NS_W'(1);
                     retry_in              = bump_retry(retry_base);
                  end
               end
            end
         end else begin
            case (item.kind)
               KIND_REQUEST: begin
                  rsp_in.send_kind      = SEND_ACK;
                  rsp_in.send_ack_code  = ACK_UNSUPPORTED;
                  rsp_in.dest_system    = item.src_system;
                  rsp_in.dest_component = item.src_component;
               end
               KIND_ACK: begin
                  rsp_in.finished    = 1'b1;
                  rsp_in.result_code = map_ack(item.ack_code, all_sent);
                  phase_in           = PH_IDLE;
               end
               KIND_TIMEOUT: begin
                  if (retry_out) begin
                     rsp_in.finished    = 1'b1;
                     rsp_in.result_code = RES_TIMEOUT;
                     phase_in           = PH_IDLE;
                  end else if (phase_ff == PH_COUNT) begin
                     rsp_in.send_kind      = SEND_COUNT;
                     rsp_in.send_value     = cfg.item_count;
                     rsp_in.dest_system    = cfg.peer_system;
                     rsp_in.dest_component = AUTOPILOT_COMP;
                     retry_in              = bump_retry(retry_ff);
                  end else begin
                     retry_in = bump_retry(retry_ff);
                  end
               end
               KIND_CANCEL: begin
                  rsp_in.send_kind      = SEND_ACK;
                  rsp_in.send_ack_code  = ACK_CANCELLED;
                  rsp_in.dest_system    = cfg.peer_system;
                  rsp_in.dest_component = AUTOPILOT_COMP;
                  rsp_in.finished       = 1'b1;
                  rsp_in.result_code    = RES_CANCELLED;
                  phase_in              = PH_IDLE;
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
endmodule

### hw/rtl/mupe_checker.sv
module mupe_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  send_kind,
   input logic [15:0] send_value,
   input logic [7:0]  send_ack_code,
   input logic [7:0]  dest_system,
   input logic [7:0]  dest_component,
   input logic        finished,
   input logic [3:0]  result_code
);
   import mupe_pkg::*;

   // no response can be pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(send_kind) && $stable(result_code))
      else $error("stalled response dropped or changed");

   a_code_needs_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !finished |-> result_code == RES_OK)
      else $error("result code without finished");

   a_none_is_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && send_kind == SEND_NONE |->
         send_value == '0 && dest_system == '0 && dest_component == '0)
      else $error("no message but destination or value set");

   a_ack_code_only_on_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && send_ack_code != '0 |-> send_kind == SEND_ACK && send_value == '0)
      else $error("ack code on a non-ack message");
endmodule

bind mission_upload_protocol_engine mupe_checker u_mupe_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .send_kind      (rsp_ch.send_kind),
   .send_value     (rsp_ch.send_value),
   .send_ack_code  (rsp_ch.send_ack_code),
   .dest_system    (rsp_ch.dest_system),
   .dest_component (rsp_ch.dest_component),
   .finished       (rsp_ch.finished),
   .result_code    (rsp_ch.result_code)
);
